### sv/lcdtce_pkg.sv
// lcdtce_pkg: shared types, constants and the microcode program of the lcd text cursor emitter
// no dependencies; used by lcd_text_cursor_command_emitter and lcdtce_checker

package lcdtce_pkg;

    // register reset values and register indexes
    localparam logic [7:0] LINE_WIDTH_RESET = 8'd21;
    localparam logic [7:0] TAB_STEP_RESET   = 8'd10;
    localparam int         CFG_IDX_W        = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_STEP   = 2'd1;

    // character codes with special handling
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] GLYPH_OFFSET   = 8'h20;

    // controller command bytes
    localparam logic [7:0] CMD_SET_ADDRESS = 8'h24;
    localparam logic [7:0] CMD_WRITE_INC   = 8'hC0;
    localparam logic [7:0] CMD_WRITE_KEEP  = 8'hC4;

    // bus byte source select
    localparam logic [1:0] BSEL_CURSOR = 2'd0;
    localparam logic [1:0] BSEL_ZERO   = 2'd1;
    localparam logic [1:0] BSEL_CONST  = 2'd2;
    localparam logic [1:0] BSEL_GLYPH  = 2'd3;

    // cursor update operations
    localparam logic [2:0] CUR_NONE = 3'd0;
    localparam logic [2:0] CUR_INC  = 3'd1;
    localparam logic [2:0] CUR_DEC  = 3'd2;
    localparam logic [2:0] CUR_TAB  = 3'd3;
    localparam logic [2:0] CUR_NL   = 3'd4;

    // remainder unit operations
    localparam logic [1:0] DIV_NONE = 2'd0;
    localparam logic [1:0] DIV_INIT = 2'd1;
    localparam logic [1:0] DIV_STEP = 2'd2;

    // sequencing
    localparam logic [1:0] JMP_NEXT    = 2'd0;
    localparam logic [1:0] JMP_GOTO    = 2'd1;
    localparam logic [1:0] JMP_DIVLOOP = 2'd2;
    localparam logic [1:0] JMP_FETCH   = 2'd3;

    // program addresses
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_FETCH    = 4'd0;
    localparam logic [PC_W-1:0] PC_PRINT    = 4'd1;
    localparam logic [PC_W-1:0] PC_BS       = 4'd6;
    localparam logic [PC_W-1:0] PC_BS_EMIT  = 4'd7;
    localparam logic [PC_W-1:0] PC_TAB      = 4'd12;
    localparam logic [PC_W-1:0] PC_NL       = 4'd13;
    localparam logic [PC_W-1:0] PC_NL_STEP  = 4'd14;
    localparam logic [PC_W-1:0] PC_NL_DONE  = 4'd15;

    typedef struct packed {
        logic            emit;
        logic            is_cmd;
        logic [1:0]      bsel;
        logic [7:0]      cbyte;
        logic            last;
        logic [2:0]      cur_op;
        logic [1:0]      div_op;
        logic [1:0]      jmp;
        logic [PC_W-1:0] target;
    } ucode_t;

    function automatic ucode_t uw(
        input logic            emit,
        input logic            is_cmd,
        input logic [1:0]      bsel,
        input logic [7:0]      cbyte,
        input logic            last,
        input logic [2:0]      cur_op,
        input logic [1:0]      div_op,
        input logic [1:0]      jmp,
        input logic [PC_W-1:0] target
    );
        ucode_t w;
        w.emit   = emit;
        w.is_cmd = is_cmd;
        w.bsel   = bsel;
        w.cbyte  = cbyte;
        w.last   = last;
        w.cur_op = cur_op;
        w.div_op = div_op;
        w.jmp    = jmp;
        w.target = target;
        return w;
    endfunction

    // microcode rom
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            // wait for a character, dispatch on its class
            PC_FETCH: w = uw(1'b0, 1'b0, BSEL_ZERO, 8'h00, 1'b0,
                             CUR_NONE, DIV_NONE, JMP_FETCH, PC_FETCH);
            // printable: address low, address high, set address, glyph, write+inc
            4'd1: w = uw(1'b1, 1'b0, BSEL_CURSOR, 8'h00, 1'b0,
                         CUR_NONE, DIV_NONE, JMP_NEXT, PC_FETCH);
            4'd2: w = uw(1'b1, 1'b0, BSEL_ZERO, 8'h00, 1'b0,
                         CUR_NONE, DIV_NONE, JMP_NEXT, PC_FETCH);
            4'd3: w = uw(1'b1, 1'b1, BSEL_CONST, CMD_SET_ADDRESS, 1'b0,
                         CUR_NONE, DIV_NONE, JMP_NEXT, PC_FETCH);
            4'd4: w = uw(1'b1, 1'b0, BSEL_GLYPH, 8'h00, 1'b0,
                         CUR_NONE, DIV_NONE, JMP_NEXT, PC_FETCH);
            4'd5: w = uw(1'b1, 1'b1, BSEL_CONST, CMD_WRITE_INC, 1'b1,
                         CUR_INC, DIV_NONE, JMP_GOTO, PC_FETCH);
            // backspace: step back, then blank that cell
            PC_BS: w = uw(1'b0, 1'b0, BSEL_ZERO, 8'h00, 1'b0,
                          CUR_DEC, DIV_NONE, JMP_GOTO, PC_BS_EMIT);
            4'd7: w = uw(1'b1, 1'b0, BSEL_CURSOR, 8'h00, 1'b0,
                         CUR_NONE, DIV_NONE, JMP_NEXT, PC_FETCH);
            4'd8: w = uw(1'b1, 1'b0, BSEL_ZERO, 8'h00, 1'b0,
                         CUR_NONE, DIV_NONE, JMP_NEXT, PC_FETCH);
            4'd9: w = uw(1'b1, 1'b1, BSEL_CONST, CMD_SET_ADDRESS, 1'b0,
                         CUR_NONE, DIV_NONE, JMP_NEXT, PC_FETCH);
            4'd10: w = uw(1'b1, 1'b0, BSEL_ZERO, 8'h00, 1'b0,
                          CUR_NONE, DIV_NONE, JMP_NEXT, PC_FETCH);
            4'd11: w = uw(1'b1, 1'b1, BSEL_CONST, CMD_WRITE_KEEP, 1'b1,
                          CUR_NONE, DIV_NONE, JMP_GOTO, PC_FETCH);
            // tab
            PC_TAB: w = uw(1'b0, 1'b0, BSEL_ZERO, 8'h00, 1'b0,
                           CUR_TAB, DIV_NONE, JMP_GOTO, PC_FETCH);
            // newline: remainder by restoring division, then align
            PC_NL: w = uw(1'b0, 1'b0, BSEL_ZERO, 8'h00, 1'b0,
                          CUR_NONE, DIV_INIT, JMP_NEXT, PC_FETCH);
            PC_NL_STEP: w = uw(1'b0, 1'b0, BSEL_ZERO, 8'h00, 1'b0,
                               CUR_NONE, DIV_STEP, JMP_DIVLOOP, PC_NL_DONE);
            PC_NL_DONE: w = uw(1'b0, 1'b0, BSEL_ZERO, 8'h00, 1'b0,
                               CUR_NL, DIV_NONE, JMP_GOTO, PC_FETCH);
            default: w = uw(1'b0, 1'b0, BSEL_ZERO, 8'h00, 1'b0,
                            CUR_NONE, DIV_NONE, JMP_GOTO, PC_FETCH);
        endcase
        return w;
    endfunction

endpackage

### sv/lcd_text_cursor_command_emitter.sv
// lcd_text_cursor_command_emitter: microcoded sequencer that turns characters into lcd bus writes
// depends on lcdtce_pkg (microcode rom, codes, register reset values)

// One character is taken per program run. The sequencer waits in its fetch step and then
// runs the program for the character class: a printable character (or any code without
// special meaning) emits five bus writes, backspace steps back and emits five writes, tab
// advances the cursor by the tab step, carriage return goes straight back to fetch, and
// newline runs the bit-serial remainder unit that aligns the cursor to the line width.
// Each emit step waits while the output register holds a write that is not yet taken, so
// stalls on the result channel lengthen a program run. Configuration writes are always
// accepted and are not held back to a character boundary: a run in progress sees them.
module lcd_text_cursor_command_emitter (
    input  logic                               aclk,
    input  logic                               aresetn,
    // character channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_char_code,
    // bus write channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_is_command,
    output logic [7:0]                         m_bus_byte,
    output logic                               m_last_of_run,
    // configuration channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lcdtce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                         cfg_data
);

    logic [lcdtce_pkg::PC_W-1:0] pc_reg, pc_next;
    logic [7:0]                  cursor_reg, cursor_next;
    logic [7:0]                  char_reg;
    logic [7:0]                  rem_reg, rem_next;
    logic [2:0]                  cnt_reg, cnt_next;
    logic [7:0]                  line_width_reg;
    logic [7:0]                  tab_step_reg;
    logic                        out_valid_reg;
    logic                        out_cmd_reg;
    logic [7:0]                  out_byte_reg;
    logic                        out_last_reg;

    lcdtce_pkg::ucode_t          uc;
    logic                        slot_free;
    logic                        step_go;
    logic                        emit_fire;
    logic [lcdtce_pkg::PC_W-1:0] dispatch_pc;
    logic [8:0]                  width9;
    logic [8:0]                  rem_shift;
    logic [8:0]                  nl_sum;
    logic [7:0]                  byte_sel;

    // control word for the current step
    assign uc = lcdtce_pkg::ucode_rom(pc_reg);

    assign slot_free = !out_valid_reg || m_ready;
    assign step_go   = !(uc.emit && !slot_free) &&
                       !(uc.jmp == lcdtce_pkg::JMP_FETCH && !s_valid);
    assign emit_fire = uc.emit && slot_free;

    assign s_ready   = (uc.jmp == lcdtce_pkg::JMP_FETCH);
    assign cfg_ready = 1'b1;

    // zero line width counts as 256
    assign width9 = {(line_width_reg == 8'd0), line_width_reg};

    // entry point by character class
    always_comb begin
        case (s_char_code)
            lcdtce_pkg::CHAR_NEWLINE:   dispatch_pc = lcdtce_pkg::PC_NL;
            lcdtce_pkg::CHAR_CR:        dispatch_pc = lcdtce_pkg::PC_FETCH;
            lcdtce_pkg::CHAR_TAB:       dispatch_pc = lcdtce_pkg::PC_TAB;
            lcdtce_pkg::CHAR_BACKSPACE: dispatch_pc = lcdtce_pkg::PC_BS;
            default:                    dispatch_pc = lcdtce_pkg::PC_PRINT;
        endcase
    end

    // step counter and jumps
    always_comb begin
        pc_next = pc_reg;
        if (step_go) begin
            case (uc.jmp)
                lcdtce_pkg::JMP_NEXT:    pc_next = pc_reg + (lcdtce_pkg::PC_W)'(1);
                lcdtce_pkg::JMP_GOTO:    pc_next = uc.target;
                lcdtce_pkg::JMP_DIVLOOP: pc_next = (cnt_reg == 3'd0) ? uc.target : pc_reg;
                lcdtce_pkg::JMP_FETCH:   pc_next = dispatch_pc;
                default:                 pc_next = lcdtce_pkg::PC_FETCH;
            endcase
        end
    end

    // remainder unit: one restoring division step per cycle
    assign rem_shift = {rem_reg, cursor_reg[cnt_reg]};

    always_comb begin
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (step_go) begin
            case (uc.div_op)
                lcdtce_pkg::DIV_INIT: begin
                    rem_next = 8'd0;
                    cnt_next = 3'd7;
                end
                lcdtce_pkg::DIV_STEP: begin
                    if (rem_shift >= width9) begin
                        rem_next = 8'(rem_shift - width9);
                    end else begin
                        rem_next = rem_shift[7:0];
                    end
                    cnt_next = cnt_reg - 3'd1;
                end
                default: begin
                    rem_next = rem_reg;
                    cnt_next = cnt_reg;
                end
            endcase
        end
    end

    // cursor update
    assign nl_sum = {1'b0, cursor_reg} + width9 - {1'b0, rem_reg};

    always_comb begin
        cursor_next = cursor_reg;
        if (step_go) begin
            case (uc.cur_op)
                lcdtce_pkg::CUR_INC: cursor_next = cursor_reg + 8'd1;
                lcdtce_pkg::CUR_DEC: cursor_next = cursor_reg - 8'd1;
                lcdtce_pkg::CUR_TAB: cursor_next = cursor_reg + tab_step_reg;
                lcdtce_pkg::CUR_NL:  cursor_next = nl_sum[7:0];
                default:             cursor_next = cursor_reg;
            endcase
        end
    end

    // bus byte source
    always_comb begin
        case (uc.bsel)
            lcdtce_pkg::BSEL_CURSOR: byte_sel = cursor_reg;
            lcdtce_pkg::BSEL_CONST:  byte_sel = uc.cbyte;
            lcdtce_pkg::BSEL_GLYPH:  byte_sel = char_reg - lcdtce_pkg::GLYPH_OFFSET;
            default:                 byte_sel = 8'd0;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= lcdtce_pkg::PC_FETCH;
            cursor_reg     <= 8'd0;
            line_width_reg <= lcdtce_pkg::LINE_WIDTH_RESET;
            tab_step_reg   <= lcdtce_pkg::TAB_STEP_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            pc_reg     <= pc_next;
            cursor_reg <= cursor_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == lcdtce_pkg::REG_LINE_WIDTH) begin
                    line_width_reg <= cfg_data;
                end else if (cfg_index == lcdtce_pkg::REG_TAB_STEP) begin
                    tab_step_reg <= cfg_data;
                end
            end
            if (emit_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (s_valid && s_ready) begin
            char_reg <= s_char_code;
        end
        if (emit_fire) begin
            out_cmd_reg  <= uc.is_cmd;
            out_byte_reg <= byte_sel;
            out_last_reg <= uc.last;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_is_command  = out_cmd_reg;
    assign m_bus_byte    = out_byte_reg;
    assign m_last_of_run = out_last_reg;

endmodule

### sv/lcdtce_checker.sv
// lcdtce_checker: port-level assertions for lcd_text_cursor_command_emitter
// depends on lcdtce_pkg (character codes); bound to the top level below

module lcdtce_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_char_code,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_is_command,
    input logic [7:0] m_bus_byte,
    input logic       m_last_of_run
);

    // a stalled write transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_command) &&
        $stable(m_bus_byte) && $stable(m_last_of_run))
        else $error("write transaction changed while stalled");

    // carriage return goes straight back to fetch
    a_cr_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_char_code == lcdtce_pkg::CHAR_CR |=> s_ready)
        else $error("carriage return did not return to fetch");

    // any other character closes the input in the cycle after it is taken
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_char_code != lcdtce_pkg::CHAR_CR |=> !s_ready)
        else $error("character accepted without a busy cycle");

    // tab runs a single cursor update step before the input reopens
    a_tab_two: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_char_code == lcdtce_pkg::CHAR_TAB |=> ##1 s_ready)
        else $error("tab did not finish in two cycles");

endmodule

bind lcd_text_cursor_command_emitter lcdtce_checker u_lcdtce_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_char_code   (s_char_code),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_is_command  (m_is_command),
    .m_bus_byte    (m_bus_byte),
    .m_last_of_run (m_last_of_run)
);
